// ===== hw/rtl/usan_pkg.sv =====
// Shared types and constants for the UTF-8 stream sanitizer.
// Used by usan_check and utf8_stream_sanitizer; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package usan_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BUF_DEPTH = 4;   // held bytes plus the incoming one
    localparam int unsigned OUT_DEPTH = 4;   // most words one input can release
    localparam int unsigned CNT_W     = 3;   // holds 0 .. 4

    typedef logic [BUF_DEPTH-1:0][BYTE_W-1:0] byte_vec_t;

    // What to do with the sequence at the head of the buffer.
    typedef enum logic [1:0] {
        HEAD_WAIT = 2'd0,
        HEAD_EMIT = 2'd1,
        HEAD_DROP = 2'd2
    } head_kind_t;

    typedef struct packed {
        head_kind_t       kind;
        logic [CNT_W-1:0] len;
    } verdict_t;

endpackage

`default_nettype wire

// ===== hw/rtl/usan_check.sv =====
// Head-of-buffer judge: decides whether the leading sequence is complete and
// valid, malformed, or still waiting for bytes. Depends on usan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usan_check (
    input  wire usan_pkg::byte_vec_t           head_bytes,
    input  wire logic [usan_pkg::CNT_W-1:0]    fill,
    output usan_pkg::verdict_t                 verdict
);

    logic [usan_pkg::BYTE_W-1:0] b0;
    logic [usan_pkg::BYTE_W-1:0] b1;
    logic [usan_pkg::CNT_W-1:0]  need;
    logic                        c1;
    logic                        c2;
    logic                        c3;
    logic                        seq_ok;

    assign b0 = head_bytes[0];
    assign b1 = head_bytes[1];
    assign c1 = (head_bytes[1] & 8'hC0) == 8'h80;
    assign c2 = (head_bytes[2] & 8'hC0) == 8'h80;
    assign c3 = (head_bytes[3] & 8'hC0) == 8'h80;

    always_comb
    begin
        if (b0 <= 8'h7F)
        begin
            need = 3'd1;
        end
        else if (b0 >= 8'hC2 && b0 <= 8'hDF)
        begin
            need = 3'd2;
        end
        else if (b0 >= 8'hE0 && b0 <= 8'hEF)
        begin
            need = 3'd3;
        end
        else if (b0 >= 8'hF0 && b0 <= 8'hF4)
        begin
            need = 3'd4;
        end
        else
        begin
            need = 3'd0;
        end
    end

    always_comb
    begin
        case (need)
            3'd1:    seq_ok = 1'b1;
            3'd2:    seq_ok = c1;
            3'd3:    seq_ok = c1 && c2 && (b0 != 8'hE0 || b1 >= 8'hA0)
                              && (b0 != 8'hED || b1 <= 8'h9F);
            3'd4:    seq_ok = c1 && c2 && c3 && (b0 != 8'hF0 || b1 >= 8'h90)
                              && (b0 != 8'hF4 || b1 <= 8'h8F);
            default: seq_ok = 1'b0;
        endcase
    end

    // A sequence is judged only once all of its bytes are present.
    always_comb
    begin
        verdict.len = need;
        if (fill == '0)
        begin
            verdict.kind = usan_pkg::HEAD_WAIT;
        end
        else if (need == '0)
        begin
            verdict.kind = usan_pkg::HEAD_DROP;
        end
        else if (fill < need)
        begin
            verdict.kind = usan_pkg::HEAD_WAIT;
        end
        else if (seq_ok)
        begin
            verdict.kind = usan_pkg::HEAD_EMIT;
        end
        else
        begin
            verdict.kind = usan_pkg::HEAD_DROP;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_sanitizer.sv =====
// Top level of the UTF-8 stream sanitizer: sequencer, byte buffer and output
// queue around the head judge. Depends on usan_pkg and usan_check.
//
// Usage:
//   Raw bytes enter on the slave channel (s_tvalid/s_tready/s_tdata). Each
//   accepted word may release zero to four bytes on the master channel
//   (m_tvalid/m_tready/m_tdata/m_tlast); m_tlast marks the final byte released
//   by that input word. Up to three bytes of an incomplete sequence are held
//   between input words.
//   Timing: one input word is handled at a time. After the word is accepted,
//   the head judge rules on the head of the buffer step by step (drop one
//   byte, take a complete sequence into the output queue byte by byte, or
//   finish), and then the released bytes are sent on the master side.
//   s_tready is high only while the block is idle.
//   Reset (rst_n low, asynchronous) empties the held bytes and the output
//   queue and leaves the block idle and ready.
//   When the receiver stalls, the current output byte holds on m_tdata and no
//   new input word is taken until the queue has drained.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_sanitizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last_of_run
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_COPY = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    localparam int unsigned IDX_W = $clog2(usan_pkg::OUT_DEPTH);

    state_t                                 state_reg, state_next;
    usan_pkg::byte_vec_t                    buf_reg, buf_next;
    logic [usan_pkg::CNT_W-1:0]             cnt_reg, cnt_next;
    logic [usan_pkg::CNT_W-1:0]             rem_reg, rem_next;
    logic [usan_pkg::CNT_W-1:0]             ocnt_reg, ocnt_next;
    logic [IDX_W-1:0]                       optr_reg, optr_next;
    logic [usan_pkg::OUT_DEPTH-1:0][7:0]    obuf_reg, obuf_next;
    usan_pkg::verdict_t                     verdict;
    logic                                   is_last;

    usan_check u_check (
        .head_bytes (buf_reg),
        .fill       (cnt_reg),
        .verdict    (verdict)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = obuf_reg[optr_reg];
    assign is_last  = ({1'b0, optr_reg} + 3'd1) == ocnt_reg;
    assign m_tlast  = is_last;

    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        ocnt_next  = ocnt_reg;
        optr_next  = optr_reg;
        obuf_next  = obuf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    buf_next[cnt_reg[IDX_W-1:0]] = s_tdata;
                    cnt_next   = cnt_reg + 3'd1;
                    ocnt_next  = '0;
                    optr_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                case (verdict.kind)
                    usan_pkg::HEAD_EMIT:
                    begin
                        rem_next   = verdict.len;
                        state_next = ST_COPY;
                    end
                    usan_pkg::HEAD_DROP:
                    begin
                        buf_next[2:0] = buf_reg[3:1];
                        cnt_next      = cnt_reg - 3'd1;
                    end
                    default:
                    begin
                        state_next = (ocnt_reg != '0) ? ST_SEND : ST_IDLE;
                    end
                endcase
            end
            ST_COPY:
            begin
                // Move one byte of the accepted sequence into the output queue.
                obuf_next[ocnt_reg[IDX_W-1:0]] = buf_reg[0];
                ocnt_next     = ocnt_reg + 3'd1;
                buf_next[2:0] = buf_reg[3:1];
                cnt_next      = cnt_reg - 3'd1;
                rem_next      = rem_reg - 3'd1;
                if (rem_reg == 3'd1)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SEND:
            begin
                if (m_tready)
                begin
                    optr_next = optr_reg + 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            ocnt_reg  <= '0;
            optr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            ocnt_reg  <= ocnt_next;
            optr_reg  <= optr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        obuf_reg <= obuf_next;
    end

    // The two channels are never open in the same cycle.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready && m_tvalid))
        else $error("input taken while output pending");

    // Between input words at most three bytes of a partial sequence remain.
    a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg <= 3'd3))
        else $error("held byte count exceeds three");

    // The output queue never overflows while bytes are copied in.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (ocnt_reg < 3'd4 && rem_reg != '0))
        else $error("output queue overflow");

    // Taking the final byte of a run returns the block to ready.
    a_last_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after final output byte");

endmodule

`default_nettype wire

// ===== sim/tb_utf8_stream_sanitizer.sv =====
// Self-checking testbench for utf8_stream_sanitizer: directed and random byte streams,
// a built-in predictor of the released bytes, and random stalls on both channels.
// Depends on usan_pkg and the sanitizer RTL.
`timescale 1ns / 1ps

module tb_utf8_stream_sanitizer;

    localparam int unsigned ITEMS_TOTAL = 330;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } released_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Predictor state: bytes of an incomplete sequence carried between input words.
    usan_pkg::byte_vec_t pend_bytes;
    int unsigned         pend_cnt = 0;
    released_t           released_q[$];

    bit          calm = 1'b0;
    int unsigned rx_hold = 0;
    int unsigned n_sent = 0;
    int unsigned n_released = 0;
    int unsigned n_errors = 0;
    int unsigned n_cycles = 0;

    utf8_stream_sanitizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tlast  (m_tlast)     // last_of_run
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d bytes still expected",
                     n_cycles, released_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: after each taken word it stalls at random, unless calm is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            rx_hold = calm ? 0 : $urandom_range(0, 3);
            m_tready <= (rx_hold == 0);
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= (rx_hold == 0);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        released_t exp_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_released++;
            if (released_q.size() == 0)
            begin
                $error("unexpected output word: out_byte %02h last_of_run %0b", m_tdata, m_tlast);
                n_errors++;
            end
            else
            begin
                exp_word = released_q.pop_front();
                if (m_tdata !== exp_word.data)
                begin
                    $error("out_byte: expected %02h, got %02h", exp_word.data, m_tdata);
                    n_errors++;
                end
                if (m_tlast !== exp_word.is_last)
                begin
                    $error("last_of_run: expected %0b, got %0b", exp_word.is_last, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    function automatic int unsigned seq_len(logic [7:0] b);
        if (b <= 8'h7F) return 1;
        if (b >= 8'hC2 && b <= 8'hDF) return 2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3;
        if (b >= 8'hF0 && b <= 8'hF4) return 4;
        return 0;
    endfunction

    function automatic bit is_tail(logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // The caller guarantees that all len bytes starting at 'at' are present.
    function automatic bit seq_good(usan_pkg::byte_vec_t w, int unsigned at, int unsigned len);
        logic [7:0] lead;
        logic [7:0] second;
        int unsigned i;
        lead = w[at];
        second = (len > 1) ? w[at + 1] : 8'h00;
        for (i = 1; i < len; i++)
        begin
            if (!is_tail(w[at + i]))
                return 1'b0;
        end
        if (lead == 8'hE0 && second < 8'hA0) return 1'b0;
        if (lead == 8'hED && second > 8'h9F) return 1'b0;
        if (lead == 8'hF0 && second < 8'h90) return 1'b0;
        if (lead == 8'hF4 && second > 8'h8F) return 1'b0;
        return 1'b1;
    endfunction

    // Appends one input byte to the pending bytes and queues every byte it releases.
    function automatic void sanitize_byte(logic [7:0] b);
        usan_pkg::byte_vec_t w;
        int unsigned n;
        int unsigned good;
        int unsigned len;
        int unsigned i;
        int unsigned n_out;
        w = pend_bytes;
        n = pend_cnt;
        w[n] = b;
        n++;
        n_out = 0;
        while (n > 0)
        begin
            good = 0;
            while (good < n)
            begin
                len = seq_len(w[good]);
                if (len == 0 || good + len > n || !seq_good(w, good, len))
                    break;
                good += len;
            end
            if (good > 0)
            begin
                for (i = 0; i < good; i++)
                begin
                    released_q.insert(released_q.size(), '{data: w[i], is_last: 1'b0});
                    n_out++;
                end
                for (i = 0; i + good < n; i++)
                    w[i] = w[i + good];
                n -= good;
                continue;
            end
            // A bad head is only judged once its lead byte's full length is present.
            len = seq_len(w[0]);
            if (len == 0 || (n >= len && !seq_good(w, 0, len)))
            begin
                for (i = 0; i + 1 < n; i++)
                    w[i] = w[i + 1];
                n--;
                continue;
            end
            break;
        end
        pend_bytes = w;
        pend_cnt = n;
        if (n_out > 0)
            released_q[released_q.size() - 1].is_last = 1'b1;
    endfunction

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sanitize_byte(b);
        n_sent++;
    endtask

    task automatic send_bytes(logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Lowers the valid and holds off until every expected byte has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (released_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_tail();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic logic [7:0] rand_lead(int unsigned len);
        case (len)
            2:       return 8'($urandom_range(8'hC2, 8'hDF));
            3:       return 8'($urandom_range(8'hE0, 8'hEF));
            default: return 8'($urandom_range(8'hF0, 8'hF4));
        endcase
    endfunction

    task automatic send_well_formed();
        int unsigned len;
        logic [7:0]  lead;
        logic [7:0]  second;
        int unsigned i;
        len = $urandom_range(1, 4);
        if (len == 1)
        begin
            send_byte(8'($urandom_range(8'h00, 8'h7F)));
        end
        else
        begin
            lead = rand_lead(len);
            case (lead)
                8'hE0:   second = 8'($urandom_range(8'hA0, 8'hBF));
                8'hED:   second = 8'($urandom_range(8'h80, 8'h9F));
                8'hF0:   second = 8'($urandom_range(8'h90, 8'hBF));
                8'hF4:   second = 8'($urandom_range(8'h80, 8'h8F));
                default: second = rand_tail();
            endcase
            send_byte(lead);
            send_byte(second);
            for (i = 2; i < len; i++)
                send_byte(rand_tail());
        end
    endtask

    task automatic send_broken();
        int unsigned len;
        int unsigned i;
        len = $urandom_range(2, 4);
        case ($urandom_range(0, 3))
            0:
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
            1:
            begin
                // Truncated sequence one byte short; a following lead or ASCII byte breaks it.
                send_byte(rand_lead(len));
                for (i = 2; i < len + $urandom_range(0, 1) && i < len; i++)
                    send_byte(rand_tail());
            end
            2:
            begin
                // Overlong, surrogate or out-of-range second byte.
                case ($urandom_range(0, 3))
                    0:
                    begin
                        len = 3;
                        send_byte(8'hE0);
                        send_byte(8'($urandom_range(8'h80, 8'h9F)));
                    end
                    1:
                    begin
                        len = 3;
                        send_byte(8'hED);
                        send_byte(8'($urandom_range(8'hA0, 8'hBF)));
                    end
                    2:
                    begin
                        len = 4;
                        send_byte(8'hF0);
                        send_byte(8'($urandom_range(8'h80, 8'h8F)));
                    end
                    default:
                    begin
                        len = 4;
                        send_byte(8'hF4);
                        send_byte(8'($urandom_range(8'h90, 8'hBF)));
                    end
                endcase
                for (i = 2; i < len; i++)
                    send_byte(rand_tail());
            end
            default:
            begin
                // A lead whose second byte is not a continuation byte.
                send_byte(rand_lead(len));
                send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                               : 8'($urandom_range(8'hC0, 8'hFF)));
                for (i = 2; i < len; i++)
                    send_byte(rand_tail());
            end
        endcase
    endtask

    task automatic test_valid_edges();
        send_bytes('{8'h00, 8'h7F});
        send_bytes('{8'hC2, 8'h80});
        send_bytes('{8'hED, 8'h9F, 8'hBF});
        send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
    endtask

    task automatic test_rejected_forms();
        // Overlong E0 form held with a non-continuation byte; only the ASCII byte survives.
        send_bytes('{8'hE0, 8'h9F, 8'h41});
        // Surrogate form: every byte is dropped and nothing is released.
        send_bytes('{8'hED, 8'hA0, 8'h80});
        // Overlong F0 form stays held across two bytes that are plainly bad already.
        send_bytes('{8'hF0, 8'h8F, 8'h41, 8'h42});
    endtask

    task automatic test_bad_leads();
        send_bytes('{8'h80, 8'hC1, 8'hF5, 8'hFF});
    endtask

    task automatic test_pause_mid_sequence();
        send_bytes('{8'h41, 8'hE2, 8'h82});
        wait_drained();
        send_byte(8'hAC);
        wait_drained();
    endtask

    task automatic test_random_text();
        int unsigned next_switch;
        next_switch = n_sent;
        while (n_sent < ITEMS_TOTAL)
        begin
            if (n_sent >= next_switch)
            begin
                calm = ($urandom_range(0, 2) == 0);
                next_switch = n_sent + 30;
            end
            if ($urandom_range(0, 3) == 0)
                send_broken();
            else
                send_well_formed();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_edges();
        test_rejected_forms();
        test_bad_leads();
        test_pause_mid_sequence();
        test_random_text();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d input words and checked %0d released words,", n_sent, n_released);
        $display("covering edge forms, rejected sequences, bad leads and random text.");
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
